/* sv/smx_pkg.sv */
// Shared types, constants and the exponential factor table for the softmax row normalizer.
`default_nettype none
package smx_pkg;
    localparam int MaxClasses = 64;
    localparam int IdxW = $clog2(MaxClasses);
    localparam int CntW = $clog2(MaxClasses + 1);

    // One closed row handed from the front part to the back part.
    typedef struct packed {
        logic [15:0]     row_max;
        logic [CntW-1:0] count;
        logic            overflow;
    } row_desc_t;

    // Factor exp(-2^b/1024) in Q2.30, built by repeated squaring at elaboration.
    function automatic logic [31:0] exp_coef(input logic [3:0] b);
        logic [63:0] c;
        c = 64'd1073741824 - 64'd1048576 + 64'd512;
        for (int k = 0; k < 16; k++) begin
            if (k < int'(b)) begin
                c = (c * c + 64'd536870912) >> 30;
            end
        end
        return c[31:0];
    endfunction

    // Constant table of the sixteen factors, one per bit of the exponent gap.
    localparam logic [31:0] ExpCoef [16] = '{
        exp_coef(4'd0),  exp_coef(4'd1),  exp_coef(4'd2),  exp_coef(4'd3),
        exp_coef(4'd4),  exp_coef(4'd5),  exp_coef(4'd6),  exp_coef(4'd7),
        exp_coef(4'd8),  exp_coef(4'd9),  exp_coef(4'd10), exp_coef(4'd11),
        exp_coef(4'd12), exp_coef(4'd13), exp_coef(4'd14), exp_coef(4'd15)
    };
endpackage
`default_nettype wire

/* sv/softmax_row_normalizer_unit.sv */
// Top level: max-subtracted softmax over rows of up to 64 logits.
// Loading accepts one logit per cycle while s_ready is high; a row then goes through
// the exponent pass (16-step multiply unit) and the normalizing pass (bit-serial
// divider), and the output waits for as long as the receiver holds off.
// The front part accepts the next row only after the last beat of the queued row is taken.
// Synchronous active-low reset clears the row state, queue and sequencer; stores need no clearing.
`default_nettype none
module softmax_row_normalizer_unit
    import smx_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [15:0] s_logit_value,
    input  wire logic        s_row_end,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic [15:0]      m_probability,
    output logic             m_final_in_row,
    output logic             m_row_overflow,
    output logic             m_valid,
    input  wire logic        m_ready
);
    logic [IdxW-1:0] rd_addr;
    logic [15:0]     rd_data;
    logic            desc_valid, desc_pop;
    row_desc_t       desc;

    smx_front u_front (.aclk, .aresetn, .s_logit_value, .s_row_end, .s_valid, .s_ready,
                       .rd_addr, .rd_data, .desc_valid, .desc, .desc_pop);
    smx_back u_back (.aclk, .aresetn, .desc_valid, .desc, .desc_pop, .rd_addr, .rd_data,
                     .m_probability, .m_final_in_row, .m_row_overflow, .m_valid, .m_ready);
endmodule
`default_nettype wire

/* sv/smx_front.sv */
// Front part: stores logits, tracks the row maximum and queues closed rows.
`default_nettype none
module smx_front
    import smx_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic [15:0]     s_logit_value,
    input  wire logic            s_row_end,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [IdxW-1:0] rd_addr,
    output logic [15:0]          rd_data,
    output logic                 desc_valid,
    output row_desc_t            desc,
    input  wire logic            desc_pop
);
    logic [15:0]     store_mem [MaxClasses];
    logic [15:0]     max_reg, max_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            ovf_reg, ovf_next;
    row_desc_t       desc_reg;
    logic [1:0]      qn_reg, qn_next;
    logic            acc, keep;

    // One row lives in the store at a time; accept only while no row is queued.
    assign s_ready = (qn_reg == 2'd0);
    assign acc     = s_valid && s_ready;
    assign keep    = cnt_reg < CntW'(MaxClasses);
    assign desc_valid = (qn_reg != 2'd0);
    assign desc       = desc_reg;

    // Store write and registered read.
    always_ff @(posedge aclk) begin
        if (acc && keep) begin
            store_mem[cnt_reg[IdxW-1:0]] <= s_logit_value;
        end
        rd_data <= store_mem[rd_addr];
    end

    // Running row state and the descriptor queue.
    always_comb begin
        max_next = max_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        qn_next  = qn_reg;
        if (desc_pop) begin
            qn_next = qn_reg - 2'd1;
        end
        if (acc) begin
            if (keep) begin
                if ($signed(s_logit_value) > $signed(max_reg)) begin
                    max_next = s_logit_value;
                end
                cnt_next = cnt_reg + CntW'(1);
            end else begin
                ovf_next = 1'b1;
            end
            if (s_row_end) begin
                qn_next  = qn_next + 2'd1;
                max_next = 16'h8000;
                cnt_next = '0;
                ovf_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= 16'h8000;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            qn_reg  <= 2'd0;
        end else begin
            max_reg <= max_next;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
            qn_reg  <= qn_next;
        end
    end

    // Capture the descriptor of the row that closes on this beat.
    always_ff @(posedge aclk) begin
        if (acc && s_row_end) begin
            desc_reg.row_max  <= (keep && $signed(s_logit_value) > $signed(max_reg))
                                 ? s_logit_value : max_reg;
            desc_reg.count    <= keep ? cnt_reg + CntW'(1) : cnt_reg;
            desc_reg.overflow <= ovf_reg || !keep;
        end
    end
endmodule
`default_nettype wire

/* sv/smx_div.sv */
// Restoring divider: 17-bit quotient of (num << 16 + den/2) / den, one bit per cycle.
`default_nettype none
module smx_div
    import smx_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [16:0] num,
    input  wire logic [22:0] den,
    output logic             done,
    output logic [15:0]      quot
);
    logic [39:0] dvd_reg;
    logic [23:0] rem_reg;
    logic [16:0] q_reg;
    logic [5:0]  n_reg;
    logic        busy_reg;
    logic [23:0] trial;
    logic [23:0] sh;

    assign sh    = {rem_reg[22:0], dvd_reg[39]};
    assign trial = sh - {1'b0, den};
    assign quot  = (q_reg > 17'd65535) ? 16'hFFFF : q_reg[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                n_reg    <= 6'd40;
                rem_reg  <= '0;
                dvd_reg  <= {7'd0, num, 16'd0} + {18'd0, den[22:1]};
                q_reg    <= '0;
            end else if (busy_reg) begin
                dvd_reg <= {dvd_reg[38:0], 1'b0};
                if (!trial[23]) begin
                    rem_reg <= trial;
                    q_reg   <= {q_reg[15:0], 1'b1};
                end else begin
                    rem_reg <= sh;
                    q_reg   <= {q_reg[15:0], 1'b0};
                end
                n_reg <= n_reg - 6'd1;
                if (n_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* sv/smx_exp.sv */
// Sequential exponential: one Q2.30 factor multiply per cycle over 16 bits of t.
`default_nettype none
module smx_exp
    import smx_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [15:0] t,
    output logic             done,
    output logic [16:0]      e
);
    logic [31:0] r_reg;
    logic [15:0] t_reg;
    logic [3:0]  b_reg;
    logic        busy_reg;
    logic [63:0] prod;
    logic [32:0] rr;

    assign prod = 64'(r_reg) * 64'(ExpCoef[b_reg]) + 64'd536870912;
    assign rr   = 33'(r_reg) + 33'd8192;
    assign e    = rr[30:14];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                r_reg    <= 32'd1073741824;
                t_reg    <= t;
                b_reg    <= 4'd0;
            end else if (busy_reg) begin
                if (t_reg[b_reg]) begin
                    r_reg <= prod[61:30];
                end
                b_reg <= b_reg + 4'd1;
                if (b_reg == 4'd15) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* sv/smx_back.sv */
// Back part: exponent pass with sum, then a normalizing pass that emits results.
`default_nettype none
module smx_back
    import smx_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            desc_valid,
    input  wire row_desc_t       desc,
    output logic                 desc_pop,
    output logic [IdxW-1:0]      rd_addr,
    input  wire logic [15:0]     rd_data,
    output logic [15:0]          m_probability,
    output logic                 m_final_in_row,
    output logic                 m_row_overflow,
    output logic                 m_valid,
    input  wire logic            m_ready
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_RD = 7'b0000010, S_EXP = 7'b0000100,
        S_EWT = 7'b0001000, S_DIV = 7'b0010000, S_DWT = 7'b0100000,
        S_OUT = 7'b1000000
    } state_t;

    state_t          st_reg;
    logic [16:0]     ev_mem [MaxClasses];
    logic [CntW-1:0] j_reg;
    logic [22:0]     sum_reg;
    logic            ex_start, ex_done, dv_start, dv_done;
    logic [16:0]     ex_e, ev_rd;
    logic [15:0]     dv_q;
    logic [16:0]     tdiff;

    assign rd_addr = j_reg[IdxW-1:0];
    assign tdiff   = {desc.row_max[15], desc.row_max} - {rd_data[15], rd_data};
    assign ex_start = (st_reg == S_EXP);
    assign dv_start = (st_reg == S_DIV);
    assign desc_pop = (st_reg == S_OUT) && m_valid && m_ready
        && (j_reg + CntW'(1) == desc.count);

    smx_exp u_exp (.aclk, .aresetn, .start(ex_start), .t(tdiff[15:0]),
                   .done(ex_done), .e(ex_e));
    smx_div u_div (.aclk, .aresetn, .start(dv_start), .num(ev_rd), .den(sum_reg),
                   .done(dv_done), .quot(dv_q));

    // Exponent store.
    always_ff @(posedge aclk) begin
        if (ex_done) begin
            ev_mem[j_reg[IdxW-1:0]] <= ex_e;
        end
        ev_rd <= ev_mem[j_reg[IdxW-1:0]];
    end

    // Row sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= S_IDLE;
            m_valid <= 1'b0;
            j_reg   <= '0;
        end else begin
            unique case (st_reg)
                S_IDLE: begin
                    j_reg   <= '0;
                    sum_reg <= '0;
                    if (desc_valid) begin
                        st_reg <= S_RD;
                    end
                end
                S_RD:  st_reg <= S_EXP;
                S_EXP: st_reg <= S_EWT;
                S_EWT: begin
                    if (ex_done) begin
                        sum_reg <= sum_reg + 23'(ex_e);
                        if (j_reg + CntW'(1) == desc.count) begin
                            j_reg  <= '0;
                            st_reg <= S_DWT;
                        end else begin
                            j_reg  <= j_reg + CntW'(1);
                            st_reg <= S_RD;
                        end
                    end
                end
                S_DWT: st_reg <= S_DIV;
                S_DIV: st_reg <= S_OUT;
                S_OUT: begin
                    if (!m_valid && dv_done) begin
                        m_valid        <= 1'b1;
                        m_probability  <= dv_q;
                        m_final_in_row <= (j_reg + CntW'(1) == desc.count);
                        m_row_overflow <= desc.overflow;
                    end else if (m_valid && m_ready) begin
                        m_valid <= 1'b0;
                        if (j_reg + CntW'(1) == desc.count) begin
                            st_reg <= S_IDLE;
                        end else begin
                            j_reg  <= j_reg + CntW'(1);
                            st_reg <= S_DWT;
                        end
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
